/* rtl/linear_probe_hash_table_unit_assert.svh */
// Assertion macros for the hash table unit. Clock clk, reset arst_n.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, codes and defaults shared by the hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_CHARS   = 8;
	localparam int DEF_VALUE_BITS  = 32;

	localparam int LEN_W   = 4;
	localparam int CAP_W   = 7;
	localparam int PADDR_W = 2;
	localparam int HASH_W  = 64;
	localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CAP_W-1:0]   CAP_RESET    = 7'd64;
	localparam logic [7:0]         CASE_OFFSET  = 8'd32;

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_SEARCH = 3'd1;
	localparam logic [2:0] REQ_ERASE  = 3'd2;
	localparam logic [2:0] REQ_FIRST  = 3'd3;
	localparam logic [2:0] REQ_NEXT   = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [63:0] key_chars;
		logic [3:0]  key_len;
		logic [31:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_key;
		logic [3:0]  out_key_len;
		logic [31:0] out_value;
		logic [5:0]  slot_index;
		logic [6:0]  entry_count;
	} rsp_t;

	function automatic rsp_t rsp_empty(logic [1:0] st, logic [6:0] cnt);
		rsp_t r;
		r = '0;
		r.status = st;
		r.entry_count = cnt;
		return r;
	endfunction

endpackage

/* rtl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/lpht_hash.sv */
// ----------------------------------------------------------------------------
// lpht_hash
// Key hash, one character a cycle, then restoring modulo by capacity.
// ----------------------------------------------------------------------------
module lpht_hash import lpht_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_CHARS   = DEF_KEY_CHARS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [8*KEY_CHARS-1:0]         key,
	input  logic [LEN_W-1:0]               len,
	input  logic [$clog2(TABLE_DEPTH):0]   cap,
	output logic                           done,
	output logic [$clog2(TABLE_DEPTH)-1:0] home
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = IW + 1;
	localparam int KW = 8 * KEY_CHARS;
	localparam int BW = $clog2(HASH_W);

	typedef enum logic [2:0] {
		HS_IDLE = 3'b001,
		HS_CHR  = 3'b010,
		HS_MOD  = 3'b100
	} hs_state_t;

	hs_state_t         state_q;
	logic [KW-1:0]     kreg_q;
	logic [LEN_W-1:0]  left_q;
	logic [HASH_W-1:0] h_q;
	logic [PW-1:0]     cap_q;
	logic [PW-1:0]     r_q;
	logic [BW-1:0]     bit_q;
	logic              done_q;
	logic [7:0]        ch;
	logic [PW:0]       r2;

	always_comb begin
		ch = kreg_q[7:0];
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			ch = ch + CASE_OFFSET;
		end
		r2 = {r_q, h_q[HASH_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				HS_IDLE: begin
					if (start) begin
						kreg_q  <= key;
						left_q  <= len;
						h_q     <= '0;
						cap_q   <= cap;
						state_q <= HS_CHR;
					end
				end
				HS_CHR: begin
					if (left_q == '0) begin
						r_q     <= '0;
						bit_q   <= '0;
						state_q <= HS_MOD;
					end else begin
						h_q    <= (h_q << 5) + h_q + HASH_W'(ch);
						kreg_q <= kreg_q >> 8;
						left_q <= left_q - 1'b1;
					end
				end
				HS_MOD: begin
					if (r2 >= {1'b0, cap_q}) begin
						r_q <= PW'(r2 - {1'b0, cap_q});
					end else begin
						r_q <= PW'(r2);
					end
					h_q   <= h_q << 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == BW'(HASH_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= HS_IDLE;
					end
				end
				default: state_q <= HS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign home = r_q[IW-1:0];
endmodule

/* rtl/linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready, one beat each, and give one response
// beat on rsp_valid/rsp_ready. One request is in work at a time.
// Insert, search, erase: accept, hash the key, reduce it modulo the capacity
// (one bit a cycle), hand over the home slot, then read and check each probed
// slot through the table RAM, which has registered read data, and post the
// response once the probe ends.
// First, next: each slot walked is read and then checked; the walk ends at a
// live entry, or with a miss once it runs past the capacity.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished request holds until the register is free.
// After reset a clearing pass writes every RAM entry empty, with req_ready
// low; the APB port takes writes throughout.
// table_capacity is at APB address 0; write it only while idle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit import lpht_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_CHARS   = DEF_KEY_CHARS,
	parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp_data
);
	`include "linear_probe_hash_table_unit_assert.svh"

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = IW + 1;
	localparam int KW = 8 * KEY_CHARS;
	localparam int MW = 2 + KW + LEN_W + VALUE_BITS;

	typedef enum logic [7:0] {
		S_CLR  = 8'b00000001,
		S_IDLE = 8'b00000010,
		S_HASH = 8'b00000100,
		S_PRD  = 8'b00001000,
		S_PCHK = 8'b00010000,
		S_WRD  = 8'b00100000,
		S_WCHK = 8'b01000000,
		S_FIN  = 8'b10000000
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [PW-1:0]         effcap;
	logic [2:0]            op_q;
	logic [KW-1:0]         key_q;
	logic [LEN_W-1:0]      len_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         n_q;
	logic [IW-1:0]         free_q;
	logic                  free_vld_q;
	logic [IW-1:0]         cursor_q;
	logic                  cur_vld_q;
	logic [PW-1:0]         live_q;
	logic [IW-1:0]         clr_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [LEN_W-1:0]      len_c;
	logic [KW-1:0]         key_c;
	logic [63:0]           v64;
	logic [VALUE_BITS-1:0] val_c;
	logic                  req_hs;
	logic                  hash_start;
	logic                  hash_done;
	logic [IW-1:0]         home;

	logic                  we;
	logic [IW-1:0]         waddr;
	logic [MW-1:0]         wdata;
	logic [MW-1:0]         rdata;
	logic [1:0]            r_mark;
	logic [KW-1:0]         r_key;
	logic [LEN_W-1:0]      r_len;
	logic [VALUE_BITS-1:0] r_val;
	logic                  hit;
	logic                  empty;
	logic                  last;
	logic                  finish;
	logic                  cand_vld;
	logic [IW-1:0]         cand;
	logic [PW-1:0]         pos_nx;
	logic [PW-1:0]         pos_inc;
	logic [PW-1:0]         walk_start;
	logic [63:0]           rv64;
	logic [63:0]           qv64;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAPACITY) ? 32'(cap_q) : '0;

	always_comb begin
		if (cap_q == '0) begin
			effcap = PW'(1);
		end else if (32'(cap_q) > 32'(TABLE_DEPTH)) begin
			effcap = PW'(TABLE_DEPTH);
		end else begin
			effcap = PW'(cap_q);
		end
	end

	// request field cleanup
	always_comb begin
		if (32'(req_data.key_len) > 32'(KEY_CHARS)) begin
			len_c = LEN_W'(KEY_CHARS);
		end else begin
			len_c = req_data.key_len;
		end
		for (int b = 0; b < KEY_CHARS; b++) begin
			key_c[8*b +: 8] = (32'(b) < 32'(len_c)) ? req_data.key_chars[8*b +: 8] : 8'd0;
		end
		v64   = 64'(req_data.entry_value);
		val_c = v64[VALUE_BITS-1:0];
	end

	assign req_ready  = (state_q == S_IDLE);
	assign req_hs     = req_valid && req_ready;
	assign hash_start = req_hs && (req_data.req_type == REQ_INSERT ||
		req_data.req_type == REQ_SEARCH || req_data.req_type == REQ_ERASE);
	assign walk_start = (req_data.req_type == REQ_FIRST || !cur_vld_q) ? '0
		: PW'({1'b0, cursor_q} + 1'b1);

	lpht_hash #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_CHARS  (KEY_CHARS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key_c),
		.len   (len_c),
		.cap   (effcap),
		.done  (hash_done),
		.home  (home)
	);

	lpht_ram #(
		.WIDTH(MW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(pos_q[IW-1:0]),
		.rdata(rdata)
	);

	// probe decode
	always_comb begin
		{r_mark, r_key, r_len, r_val} = rdata;
		rv64     = 64'(r_val);
		qv64     = 64'(val_q);
		empty    = (r_mark == MARK_EMPTY);
		hit      = (r_mark == MARK_LIVE) && (r_len == len_q) && (r_key == key_q);
		pos_inc  = pos_q + 1'b1;
		last     = (PW'(n_q + 1'b1) == effcap);
		pos_nx   = (pos_inc == effcap) ? '0 : pos_inc;
		finish   = hit || empty || last;
		cand_vld = free_vld_q || (r_mark != MARK_LIVE);
		cand     = free_vld_q ? free_q : pos_q[IW-1:0];

		we    = 1'b0;
		waddr = pos_q[IW-1:0];
		wdata = '0;
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (state_q == S_PCHK && finish) begin
			if (op_q == REQ_INSERT && !hit && cand_vld) begin
				we    = 1'b1;
				waddr = cand;
				wdata = {MARK_LIVE, key_q, len_q, val_q};
			end else if (op_q == REQ_ERASE && hit) begin
				we    = 1'b1;
				wdata = {MARK_TOMB, r_key, r_len, r_val};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			live_q      <= '0;
			cur_vld_q   <= 1'b0;
			cursor_q    <= '0;
			free_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_hs) begin
						op_q  <= req_data.req_type;
						key_q <= key_c;
						len_q <= len_c;
						val_q <= val_c;
						if (hash_start) begin
							state_q <= S_HASH;
						end else if (req_data.req_type == REQ_FIRST ||
							req_data.req_type == REQ_NEXT) begin
							pos_q   <= walk_start;
							state_q <= S_WRD;
						end else begin
							res_q   <= rsp_empty(ST_MISS, 7'(live_q));
							state_q <= S_FIN;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						pos_q      <= PW'(home);
						n_q        <= '0;
						free_vld_q <= 1'b0;
						state_q    <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (finish) begin
						state_q <= S_FIN;
						if (op_q == REQ_INSERT) begin
							if (hit) begin
								res_q <= rsp_empty(ST_DUP, 7'(live_q));
							end else if (cand_vld) begin
								live_q    <= live_q + 1'b1;
								cursor_q  <= cand;
								cur_vld_q <= 1'b1;
								res_q     <= '{status: ST_OK, out_key: 64'(key_q),
									out_key_len: len_q, out_value: qv64[31:0],
									slot_index: 6'(cand), entry_count: 7'(live_q + 1'b1)};
							end else begin
								res_q <= rsp_empty(ST_FULL, 7'(live_q));
							end
						end else if (hit) begin
							cursor_q  <= pos_q[IW-1:0];
							cur_vld_q <= 1'b1;
							res_q     <= '{status: ST_OK, out_key: 64'(r_key),
								out_key_len: r_len, out_value: rv64[31:0],
								slot_index: 6'(pos_q),
								entry_count: (op_q == REQ_ERASE && live_q != '0)
									? 7'(live_q - 1'b1) : 7'(live_q)};
							if (op_q == REQ_ERASE && live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
						end else begin
							res_q <= rsp_empty(ST_MISS, 7'(live_q));
						end
					end else begin
						if (r_mark != MARK_LIVE && !free_vld_q) begin
							free_q     <= pos_q[IW-1:0];
							free_vld_q <= 1'b1;
						end
						pos_q   <= pos_nx;
						n_q     <= n_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_WRD: begin
					if (pos_q >= effcap) begin
						res_q   <= rsp_empty(ST_MISS, 7'(live_q));
						state_q <= S_FIN;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (r_mark == MARK_LIVE) begin
						cursor_q  <= pos_q[IW-1:0];
						cur_vld_q <= 1'b1;
						res_q     <= '{status: ST_OK, out_key: 64'(r_key),
							out_key_len: r_len, out_value: rv64[31:0],
							slot_index: 6'(pos_q), entry_count: 7'(live_q)};
						state_q   <= S_FIN;
					end else begin
						pos_q   <= pos_inc;
						state_q <= S_WRD;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`LPHT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
	`LPHT_ASSERT_NOW(a_count_range, 1'b1, 32'(live_q) <= 32'(TABLE_DEPTH), "live count overflow")
	`LPHT_ASSERT_NEXT(a_fin_posts, (state_q == S_FIN) && (!rsp_valid_q || rsp_ready), rsp_valid && (state_q == S_IDLE), "finished response not posted")
endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear probing hash table unit. It walks a short
// table of directed requests, then several phases of random requests, each
// after a write of the table capacity. A predictor keeps its own copy of the
// slots and the cursor and works out each response beat; the bench compares
// every returned beat, field by field, with the predicted one or a fixed one.
// ----------------------------------------------------------------------------
module testbench import lpht_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEF_TABLE_DEPTH;
	localparam int KCHARS     = DEF_KEY_CHARS;
	localparam logic [63:0] HASH_MULT = 64'd33;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int PHASE_ITEMS = 200;
	localparam int POOL_SIZE   = 24;
	localparam int NUM_PHASES  = 10;

	typedef struct {
		req_t r;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid, req_ready;
	req_t        req_data;
	logic        rsp_valid, rsp_ready;
	rsp_t        rsp_data;

	logic [1:0]  tbl_mark [DEPTH];
	logic [63:0] tbl_key  [DEPTH];
	logic [3:0]  tbl_len  [DEPTH];
	logic [31:0] tbl_val  [DEPTH];
	int          live_cnt;
	bit          cur_valid;
	int          cur_slot;
	logic [6:0]  cap_reg;

	rsp_t        pending_rsp[$];
	bit          fixed_flag[$];
	rsp_t        fixed_rsp[$];
	int          errors;
	int          cycles;
	int          beats_in, beats_out, cfg_writes;
	bit          quiet;
	int          stall_left;
	logic [63:0] pool_key [POOL_SIZE];
	logic [3:0]  pool_len [POOL_SIZE];
	dir_row_t    dir_rows[$];

	int          cap_plan [NUM_PHASES] = '{64, 1, 0, 127, 5, 17, 64, 3, 40, 64};

	linear_probe_hash_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int eff_cap();
		if (cap_reg == 7'd0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return cap_reg;
	endfunction

	function automatic int home_of(logic [63:0] k, int n, int cap);
		logic [63:0] h;
		logic [7:0]  c;
		h = '0;
		for (int i = 0; i < n; i++) begin
			c = k[8*i +: 8];
			if (c >= 8'h41 && c <= 8'h5A)
				c = c + CASE_OFFSET;
			h = h * HASH_MULT + {56'd0, c};
		end
		return int'(h % cap);
	endfunction

	function automatic int locate(logic [63:0] k, int n, int cap);
		int s;
		s = home_of(k, n, cap);
		for (int i = 0; i < cap; i++) begin
			if (tbl_mark[s] == MARK_EMPTY)
				return -1;
			if (tbl_mark[s] == MARK_LIVE && tbl_len[s] == n && tbl_key[s] == k)
				return s;
			s = (s + 1) % cap;
		end
		return -1;
	endfunction

	function automatic rsp_t hit_rsp(int s);
		rsp_t o;
		o = '0;
		o.status      = ST_OK;
		o.out_key     = tbl_key[s];
		o.out_key_len = tbl_len[s];
		o.out_value   = tbl_val[s];
		o.slot_index  = s[5:0];
		return o;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		int          n, cap, s, t, start;
		logic [63:0] k;
		rsp_t        o;
		n = (r.key_len > KCHARS) ? KCHARS : int'(r.key_len);
		k = '0;
		for (int i = 0; i < KCHARS; i++)
			if (i < n)
				k[8*i +: 8] = r.key_chars[8*i +: 8];
		cap = eff_cap();
		o = rsp_empty(ST_MISS, 7'd0);
		case (r.req_type)
			REQ_INSERT: begin
				if (locate(k, n, cap) >= 0) begin
					o = rsp_empty(ST_DUP, 7'd0);
				end else begin
					o = rsp_empty(ST_FULL, 7'd0);
					t = home_of(k, n, cap);
					for (int i = 0; i < cap; i++) begin
						if (tbl_mark[t] != MARK_LIVE) begin
							tbl_mark[t] = MARK_LIVE;
							tbl_key[t]  = k;
							tbl_len[t]  = n[3:0];
							tbl_val[t]  = r.entry_value;
							live_cnt++;
							cur_slot  = t;
							cur_valid = 1'b1;
							o = hit_rsp(t);
							break;
						end
						t = (t + 1) % cap;
					end
				end
			end
			REQ_SEARCH, REQ_ERASE: begin
				s = locate(k, n, cap);
				if (s >= 0) begin
					cur_slot  = s;
					cur_valid = 1'b1;
					o = hit_rsp(s);
					if (r.req_type == REQ_ERASE) begin
						tbl_mark[s] = MARK_TOMB;
						if (live_cnt > 0)
							live_cnt--;
					end
				end
			end
			REQ_FIRST, REQ_NEXT: begin
				start = (r.req_type == REQ_FIRST || !cur_valid) ? 0 : cur_slot + 1;
				for (int i = start; i < cap; i++) begin
					if (tbl_mark[i] == MARK_LIVE) begin
						cur_slot  = i;
						cur_valid = 1'b1;
						o = hit_rsp(i);
						break;
					end
				end
			end
			default: ;
		endcase
		o.entry_count = live_cnt[6:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_valid && rsp_ready) begin
			got = rsp_data;
			beats_out++;
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected beat", 64'(got), 64'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.out_key != want.out_key)
					report_mismatch("out_key", got.out_key, want.out_key);
				if (got.out_key_len != want.out_key_len)
					report_mismatch("out_key_len", 64'(got.out_key_len),
						64'(want.out_key_len));
				if (got.out_value != want.out_value)
					report_mismatch("out_value", 64'(got.out_value), 64'(want.out_value));
				if (got.slot_index != want.slot_index)
					report_mismatch("slot_index", 64'(got.slot_index),
						64'(want.slot_index));
				if (got.entry_count != want.entry_count)
					report_mismatch("entry_count", 64'(got.entry_count),
						64'(want.entry_count));
			end
		end
		if (arst_n && req_valid && req_ready) begin
			beats_in++;
			want = apply_request(req_data);
			if (fixed_flag.size() != 0 && fixed_flag.pop_front())
				want = fixed_rsp.pop_front();
			pending_rsp.push_back(want);
		end
	end

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready = 1'b0;
		end else begin
			stall_left = pick_gap();
			rsp_ready = (stall_left == 0);
		end
	end

	task automatic send_beat(req_t r, bit fixed, rsp_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		fixed_flag.push_back(fixed);
		if (fixed)
			fixed_rsp.push_back(want);
		req_data  = r;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic write_capacity(int value);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = REG_CAPACITY;
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cap_reg = pwdata[6:0];
		cfg_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic req_t make_req(logic [2:0] op, logic [63:0] k, logic [3:0] n,
			logic [31:0] v);
		req_t r;
		r.req_type    = op;
		r.key_chars   = k;
		r.key_len     = n;
		r.entry_value = v;
		return r;
	endfunction

	function automatic void add_row(req_t r, bit fixed, rsp_t want);
		dir_row_t row;
		row.r     = r;
		row.fixed = fixed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 4))
			0: return 8'h41 + 8'($urandom_range(0, 25));
			1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void fill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_len[i] = 4'($urandom_range(0, KCHARS));
			pool_key[i] = '0;
			for (int j = 0; j < KCHARS; j++)
				pool_key[i][8*j +: 8] = rand_char();
		end
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   roll, p;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			r.req_type = REQ_INSERT;
		else if (roll < 55)
			r.req_type = REQ_SEARCH;
		else if (roll < 70)
			r.req_type = REQ_ERASE;
		else if (roll < 78)
			r.req_type = REQ_FIRST;
		else if (roll < 94)
			r.req_type = REQ_NEXT;
		else
			r.req_type = 3'($urandom_range(5, 7));
		r.entry_value = $urandom();
		if ($urandom_range(0, 99) < 80) begin
			p = $urandom_range(0, POOL_SIZE - 1);
			r.key_chars = pool_key[p];
			r.key_len   = pool_len[p];
			for (int j = 0; j < KCHARS; j++)
				if (j >= pool_len[p] && $urandom_range(0, 1))
					r.key_chars[8*j +: 8] = 8'($urandom_range(0, 255));
			if (pool_len[p] == KCHARS && $urandom_range(0, 3) == 0)
				r.key_len = 4'($urandom_range(KCHARS, 15));
		end else begin
			r.key_chars = {$urandom(), $urandom()};
			r.key_len   = 4'($urandom_range(0, 15));
		end
		return r;
	endfunction

	initial begin
		rsp_t none;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req_data  = '0;
		rsp_ready = 1'b0;
		errors    = 0;
		cycles    = 0;
		stall_left = 0;
		quiet     = 1'b0;
		none      = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_mark[i] = MARK_EMPTY;
			tbl_key[i]  = '0;
			tbl_len[i]  = '0;
			tbl_val[i]  = '0;
		end
		live_cnt  = 0;
		cur_valid = 1'b0;
		cur_slot  = 0;
		cap_reg   = CAP_RESET;

		add_row(make_req(REQ_SEARCH, 64'h6B, 4'd1, 32'd0), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(REQ_FIRST, '0, '0, '0), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(REQ_NEXT, '0, '0, '0), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(3'd5, '1, 4'd15, '1), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(3'd7, '0, '0, '0), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(REQ_ERASE, 64'h6241, 4'd2, '0), 1, rsp_empty(ST_MISS, 7'd0));
		add_row(make_req(REQ_INSERT, 64'h6241, 4'd2, '1), 0, none);
		add_row(make_req(REQ_INSERT, 64'h6241, 4'd2, 32'd5), 1, rsp_empty(ST_DUP, 7'd1));
		add_row(make_req(REQ_SEARCH, 64'h4261, 4'd2, '0), 0, none);
		add_row(make_req(REQ_SEARCH, 64'hFFFF_FFFF_FFFF_6241, 4'd2, '0), 0, none);
		add_row(make_req(REQ_INSERT, '1, 4'd15, 32'd0), 0, none);
		add_row(make_req(REQ_INSERT, '1, 4'd0, 32'd1), 0, none);
		add_row(make_req(REQ_INSERT, 64'hFF00_0000, 4'd2, 32'd2), 0, none);
		add_row(make_req(REQ_SEARCH, '1, 4'd8, '0), 0, none);
		add_row(make_req(REQ_FIRST, '0, '0, '0), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);
		add_row(make_req(REQ_ERASE, 64'h6241, 4'd2, '0), 0, none);
		add_row(make_req(REQ_SEARCH, 64'h6241, 4'd2, '0), 0, none);
		add_row(make_req(REQ_INSERT, 64'h6241, 4'd2, 32'hA5A5_5A5A), 0, none);
		add_row(make_req(REQ_NEXT, '0, '0, '0), 0, none);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].want);
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_capacity(cap_plan[ph]);
			quiet = (ph % 3 == 2);
			fill_pool();
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_beat(rand_req(), 0, none);
			drain();
		end

		$display("requests %0d, responses %0d, capacity writes %0d over %0d phases",
			beats_in, beats_out, cfg_writes, NUM_PHASES);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
